/* design/cstfo_pkg.sv */
// Shared types, constants and helpers for the CD sector to file offset unit.
// No dependencies; every other design file imports this package.
package cstfo_pkg;

  localparam int MAX_TRACKS = 128;
  localparam int IDX_W      = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

  localparam int SECTOR_W = 20;
  localparam int SKIP_W   = 32;
  localparam int FILE_W   = 8;
  localparam int TRACK_W  = 8;
  localparam int OFFSET_W = 33;
  localparam int LEN_W    = 12;
  localparam int PROD_W   = 32;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_RAWERR  = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  localparam logic [1:0] SZ_2048     = 2'd0;
  localparam logic [1:0] SZ_2336     = 2'd1;
  localparam logic [1:0] SZ_2352     = 2'd2;
  localparam logic [1:0] SZ_2352_ALT = 2'd3;

  localparam logic [LEN_W-1:0] RAW_LEN    = LEN_W'(2352);
  localparam logic [LEN_W-1:0] COOKED_LEN = LEN_W'(2048);
  localparam logic [LEN_W-1:0] FORM2_LEN  = LEN_W'(2336);
  localparam logic [4:0]       MODE1_HDR  = 5'd16;
  localparam logic [4:0]       MODE2_HDR  = 5'd24;

  typedef struct packed {
    logic [FILE_W-1:0]   file_id;
    logic                mode2;
    logic [1:0]          size_code;
    logic [SKIP_W-1:0]   skip;
    logic [SECTOR_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic                is_write;
    logic                slot_ok;
    logic [IDX_W-1:0]    slot;
    entry_t              entry;
    logic [SECTOR_W-1:0] sector;
    logic                raw;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TRACK_W-1:0]  track_number;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LEN_W-1:0]    read_length;
    logic [FILE_W-1:0]   file_id;
  } res_t;

  // Codes 2 and 3 both mean 2352 bytes per sector.
  function automatic logic [LEN_W-1:0] size_of(input logic [1:0] code);
    logic [LEN_W-1:0] sz;
    if (code == SZ_2048) sz = COOKED_LEN;
    else if (code == SZ_2336) sz = FORM2_LEN;
    else sz = RAW_LEN;
    return sz;
  endfunction

endpackage

/* design/cstfo_ifs.sv */
// Channel interfaces: request, response and configuration write.
// Depends on cstfo_pkg for field widths.
interface cstfo_req_if import cstfo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [6:0]          entry_index;
  logic [SECTOR_W-1:0] entry_start;
  logic [SKIP_W-1:0]   entry_skip;
  logic [1:0]          entry_size_code;
  logic                entry_mode2;
  logic [FILE_W-1:0]   entry_file_id;
  logic [SECTOR_W-1:0] sector;
  logic                raw_request;

  modport source (output valid, kind, entry_index, entry_start, entry_skip, entry_size_code,
                  entry_mode2, entry_file_id, sector, raw_request, input ready);
  modport sink   (input valid, kind, entry_index, entry_start, entry_skip, entry_size_code,
                  entry_mode2, entry_file_id, sector, raw_request, output ready);
endinterface

interface cstfo_rsp_if import cstfo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [TRACK_W-1:0]  track_number;
  logic [OFFSET_W-1:0] byte_offset;
  logic [LEN_W-1:0]    read_length;
  logic [FILE_W-1:0]   file_id;

  modport source (output valid, status, track_number, byte_offset, read_length, file_id,
                  input ready);
  modport sink   (input valid, status, track_number, byte_offset, read_length, file_id,
                  output ready);
endinterface

interface cstfo_cfg_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/cstfo_front.sv */
// Front end: takes requests, classifies them into commands, and queues them.
// Depends on cstfo_pkg and cstfo_req_if.
module cstfo_front import cstfo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cstfo_req_if.sink   req,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        pop
);

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd;

  always_comb begin
    cmd.is_write        = (req.kind == KIND_WRITE);
    cmd.slot_ok         = (int'(req.entry_index) < MAX_TRACKS);
    cmd.slot            = IDX_W'(req.entry_index);
    cmd.entry.start     = req.entry_start;
    cmd.entry.skip      = req.entry_skip;
    cmd.entry.size_code = req.entry_size_code;
    cmd.entry.mode2     = req.entry_mode2;
    cmd.entry.file_id   = req.entry_file_id;
    cmd.sector          = req.sector;
    cmd.raw             = req.raw_request;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/cstfo_back.sv */
// Back end: owns the track table, runs table writes and the linear track scan,
// computes the file offset and holds the result register. Depends on cstfo_pkg.
module cstfo_back import cstfo_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] track_count,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state;
  entry_t              mem [MAX_TRACKS];
  entry_t              mem_q;
  entry_t              prev;
  logic [CNT_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    scan_inc;
  logic [IDX_W-1:0]    raddr;
  logic [CNT_W-1:0]    n_tracks;
  logic [SECTOR_W-1:0] sector;
  logic                raw;
  logic [PROD_W-1:0]   product;
  res_t                res;
  logic                mem_we;
  logic                hit;
  logic                raw_track;
  logic [LEN_W-1:0]    size;
  logic [SECTOR_W-1:0] diff;
  logic [4:0]          hdr;
  logic                load_out;

  function automatic res_t status_only(input logic [1:0] st);
    res_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  always_comb begin
    if (int'(track_count) > MAX_TRACKS) n_tracks = CNT_W'(MAX_TRACKS);
    else n_tracks = CNT_W'(track_count);
  end

  assign busy     = (state != S_IDLE);
  assign pop      = (state == S_IDLE) && q_valid;
  assign mem_we   = pop && q_cmd.is_write && q_cmd.slot_ok;
  assign scan_inc = scan_idx + CNT_W'(1);
  // Prefetch the next slot while the current one is compared.
  assign raddr    = (state == S_SCAN) ? scan_inc[IDX_W-1:0] : '0;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (mem_we) mem[q_cmd.slot] <= q_cmd.entry;
    mem_q <= mem[raddr];
  end

  assign hit       = (prev.start <= sector) && (sector < mem_q.start);
  assign raw_track = (prev.size_code != SZ_2048) && (prev.size_code != SZ_2336);
  assign size      = size_of(prev.size_code);
  assign diff      = sector - prev.start;

  always_comb begin
    if (raw) hdr = 5'd0;
    else if (prev.mode2) hdr = MODE2_HDR;
    else if (raw_track) hdr = MODE1_HDR;
    else hdr = 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            sector <= q_cmd.sector;
            raw    <= q_cmd.raw;
            if (q_cmd.is_write) begin
              res   <= status_only(ST_WRITTEN);
              state <= S_DONE;
            end else if (n_tracks < CNT_W'(2)) begin
              res   <= status_only(ST_NONE);
              state <= S_DONE;
            end else begin
              res      <= '0;
              scan_idx <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx == '0) begin
            prev     <= mem_q;
            scan_idx <= scan_inc;
          end else if (hit) begin
            // prev holds the matching slot; its track number is scan_idx
            state <= S_CHECK;
          end else if (scan_inc == n_tracks) begin
            res.status <= ST_NONE;
            state      <= S_DONE;
          end else begin
            prev     <= mem_q;
            scan_idx <= scan_inc;
          end
        end
        S_CHECK: begin
          res.track_number <= TRACK_W'(scan_idx);
          product          <= PROD_W'(diff) * PROD_W'(size);
          if (raw && !raw_track) begin
            res.status <= ST_RAWERR;
            state      <= S_DONE;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          res.status      <= ST_OK;
          res.byte_offset <= OFFSET_W'(prev.skip) + OFFSET_W'(product) + OFFSET_W'(hdr);
          res.read_length <= raw ? RAW_LEN : COOKED_LEN;
          res.file_id     <= prev.file_id;
          state           <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_res <= res;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/cd_sector_to_file_offset_unit.sv */
// Top level of the CD sector to file offset unit: config register, front end,
// back end. Depends on cstfo_pkg, the channel interfaces, cstfo_front, cstfo_back.
//
//   channel  dir  payload
//   cfg_ch   in   track_count (8 bits), always ready
//   req_ch   in   kind, entry_* fields, sector, raw_request
//   rsp_ch   out  status, track_number, byte_offset, read_length, file_id
//
// Back end: a table write, or a translate with fewer than two entries, goes from issue
// straight to result load. A translate that hits slot h runs issue, a scan on the single
// table read port, check, add and result load; a raw request on a non-raw track skips
// the add. A miss ends the scan at n = min(track_count, 128). Requests wait in a
// two-entry queue; the result register lets the next request start while a result
// waits. Synchronous reset clears track_count and control state, not the track table.
module cd_sector_to_file_offset_unit import cstfo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cstfo_cfg_if.sink   cfg_ch,
  cstfo_req_if.sink   req_ch,
  cstfo_rsp_if.source rsp_ch
);

  logic [7:0] track_count;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       pop;
  logic       busy;
  logic       out_valid;
  res_t       out_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) track_count <= 8'd0;
    else if (cfg_ch.valid && cfg_ch.ready) track_count <= cfg_ch.data;
  end

  cstfo_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop)
  );

  cstfo_back u_back (
    .clk         (clk),
    .rst         (rst),
    .track_count (track_count),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_ready   (rsp_ch.ready),
    .out_res     (out_res)
  );

  assign rsp_ch.valid        = out_valid;
  assign rsp_ch.status       = out_res.status;
  assign rsp_ch.track_number = out_res.track_number;
  assign rsp_ch.byte_offset  = out_res.byte_offset;
  assign rsp_ch.read_length  = out_res.read_length;
  assign rsp_ch.file_id      = out_res.file_id;

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> !busy)
    else $error("back end took a command while busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_ch.valid) |-> $past(busy))
    else $error("result appeared without back end work");

endmodule

/* tb/tb_cd_sector_to_file_offset_unit.sv */
`timescale 1ns / 1ps
// Testbench for the CD sector to file offset unit: table writes and sector translates.
// Depends on cstfo_pkg, the channel interfaces and cd_sector_to_file_offset_unit.
module tb_cd_sector_to_file_offset_unit;
  import cstfo_pkg::*;

  typedef struct {
    logic                kind;
    logic [6:0]          index;
    entry_t              ent;
    logic [SECTOR_W-1:0] sector;
    logic                raw;
  } track_req_t;

  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_PAD     = 8;
  localparam int END_PAD      = 150;

  logic clk;
  logic rst;

  cstfo_cfg_if cfg_ch ();
  cstfo_req_if req_ch ();
  cstfo_rsp_if rsp_ch ();

  cd_sector_to_file_offset_unit uut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  // Mirror of the block: track table, track count and results still owed.
  entry_t      track_mirror [MAX_TRACKS];
  int          track_count_mirror = 0;
  res_t        pending_results [$];
  int unsigned items_sent = 0;
  int          mismatches = 0;

  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int rsp_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic res_t expected_translation(input track_req_t r);
    res_t             res;
    entry_t           e;
    int               n;
    int               hit;
    int               s;
    logic [LEN_W-1:0] bps;
    logic [63:0]      off;
    res = '0;
    if (r.kind == KIND_WRITE) begin
      if (r.index < MAX_TRACKS) track_mirror[r.index] = r.ent;
      res.status = ST_WRITTEN;
      return res;
    end
    n = (track_count_mirror > MAX_TRACKS) ? MAX_TRACKS : track_count_mirror;
    hit = -1;
    // First slot in table order wins, even when the table is unsorted.
    for (s = 0; s + 1 < n && hit < 0; s++) begin
      if (track_mirror[s].start <= r.sector && r.sector < track_mirror[s + 1].start)
        hit = s;
    end
    if (hit < 0) begin
      res.status = ST_NONE;
      return res;
    end
    e = track_mirror[hit];
    res.track_number = TRACK_W'(hit + 1);
    case (e.size_code)
      SZ_2048: bps = COOKED_LEN;
      SZ_2336: bps = FORM2_LEN;
      default: bps = RAW_LEN;
    endcase
    if (r.raw && bps != RAW_LEN) begin
      res.status = ST_RAWERR;
      return res;
    end
    off = 64'(e.skip) + (64'(r.sector) - 64'(e.start)) * 64'(bps);
    if (!r.raw && bps == RAW_LEN && !e.mode2) off += 64'(MODE1_HDR);
    if (!r.raw && e.mode2) off += 64'(MODE2_HDR);
    res.status      = ST_OK;
    res.byte_offset = off[OFFSET_W-1:0];
    res.read_length = r.raw ? RAW_LEN : COOKED_LEN;
    res.file_id     = e.file_id;
    return res;
  endfunction

  function automatic track_req_t table_write(input int slot, input logic [19:0] start,
                                             input logic [31:0] skip, input logic [1:0] code,
                                             input logic m2, input logic [7:0] fid);
    track_req_t r;
    r.kind          = KIND_WRITE;
    r.index         = 7'(slot);
    r.ent.start     = start;
    r.ent.skip      = skip;
    r.ent.size_code = code;
    r.ent.mode2     = m2;
    r.ent.file_id   = fid;
    r.sector        = SECTOR_W'($urandom);
    r.raw           = 1'($urandom);
    return r;
  endfunction

  // Fill the unused write fields with junk so decode slips show up.
  function automatic track_req_t sector_lookup(input logic [19:0] sector, input logic raw);
    track_req_t r;
    r.kind          = KIND_XLATE;
    r.index         = 7'($urandom);
    r.ent.start     = SECTOR_W'($urandom);
    r.ent.skip      = $urandom;
    r.ent.size_code = 2'($urandom);
    r.ent.mode2     = 1'($urandom);
    r.ent.file_id   = 8'($urandom);
    r.sector        = sector;
    r.raw           = raw;
    return r;
  endfunction

  // Aim mostly inside tracks, some at boundaries, the rest anywhere.
  function automatic logic [19:0] pick_sector(input int n);
    int s;
    int lo;
    int hi;
    int r;
    r = $urandom_range(0, 9);
    if (n < 2 || r >= 8) return SECTOR_W'($urandom);
    if (r >= 6) begin
      s  = $urandom_range(0, n - 1);
      lo = track_mirror[s].start;
      return (r == 6 || lo == 0) ? SECTOR_W'(lo) : SECTOR_W'(lo - 1);
    end
    s  = $urandom_range(0, n - 2);
    lo = track_mirror[s].start;
    hi = track_mirror[s + 1].start;
    if (hi > lo) return SECTOR_W'(lo + $urandom_range(0, hi - lo - 1));
    return SECTOR_W'(lo);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input track_req_t r);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.kind            <= r.kind;
    req_ch.entry_index     <= r.index;
    req_ch.entry_start     <= r.ent.start;
    req_ch.entry_skip      <= r.ent.skip;
    req_ch.entry_size_code <= r.ent.size_code;
    req_ch.entry_mode2     <= r.ent.mode2;
    req_ch.entry_file_id   <= r.ent.file_id;
    req_ch.sector          <= r.sector;
    req_ch.raw_request     <= r.raw;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.insert(pending_results.size(), expected_translation(r));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results(input int pad);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_track_count(input int n);
    drain_results(IDLE_PAD);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= 8'(n);
    do @(posedge clk); while (!cfg_ch.ready);
    track_count_mirror = n;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_track_table(input int n, input bit sorted);
    logic [19:0] starts [MAX_TRACKS];
    logic [19:0] t;
    int          pos;
    int          gap_cap;
    int          a;
    int          b;
    int          s;
    pos = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4000);
    for (s = 0; s < n; s++) begin
      starts[s] = SECTOR_W'(pos);
      gap_cap = (32'hFFFFF - pos) / (n - s);
      if ($urandom_range(0, 1) && gap_cap > 64) gap_cap = 64;
      pos += $urandom_range(0, gap_cap);
    end
    if (n > 1 && $urandom_range(0, 3) == 0) starts[n - 1] = 20'hFFFFF;
    if (!sorted && n > 2) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      t = starts[a];
      starts[a] = starts[b];
      starts[b] = t;
    end
    for (s = 0; s < n; s++)
      send_req(table_write(s, starts[s], $urandom, 2'($urandom), 1'($urandom),
                           8'($urandom)));
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  res_t want_res;
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status %0d", rsp_ch.status);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("status", 64'(want_res.status), 64'(rsp_ch.status));
        check_field("track_number", 64'(want_res.track_number), 64'(rsp_ch.track_number));
        check_field("byte_offset", 64'(want_res.byte_offset), 64'(rsp_ch.byte_offset));
        check_field("read_length", 64'(want_res.read_length), 64'(rsp_ch.read_length));
        check_field("file_id", 64'(want_res.file_id), 64'(rsp_ch.file_id));
      end
    end
  end

  // Response side: long hold when asked, otherwise random stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold_cycles--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (snk_idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Reset count is zero: every lookup misses, then a one-entry table misses too.
  task automatic test_empty_table();
    send_req(sector_lookup(20'h00000, 1'b0));
    send_req(sector_lookup(20'hFFFFF, 1'b1));
    send_req(table_write(0, 20'd0, 32'd0, SZ_2048, 1'b0, 8'd0));
    set_track_count(1);
    send_req(sector_lookup(20'h00000, 1'b0));
  endtask

  task automatic test_track_types();
    send_req(table_write(0, 20'd150, 32'd1000, SZ_2352, 1'b0, 8'd1));
    send_req(table_write(1, 20'd1000, 32'h1000_0000, SZ_2336, 1'b1, 8'd2));
    send_req(table_write(2, 20'd2000, 32'd5, SZ_2048, 1'b0, 8'd3));
    send_req(table_write(3, 20'd3000, 32'hFFFF_FFFF, SZ_2352_ALT, 1'b1, 8'hFF));
    send_req(table_write(4, 20'hFFFFF, 32'd0, SZ_2048, 1'b0, 8'd0));
    set_track_count(5);
    send_req(sector_lookup(20'd150, 1'b0));      // mode 1 raw track, cooked read
    send_req(sector_lookup(20'd151, 1'b1));
    send_req(sector_lookup(20'd149, 1'b0));      // before the first track
    send_req(sector_lookup(20'd1500, 1'b0));     // mode 2 header skip
    send_req(sector_lookup(20'd1500, 1'b1));     // raw on a 2336 track
    send_req(sector_lookup(20'd2000, 1'b0));
    send_req(sector_lookup(20'd2999, 1'b1));     // raw on a 2048 track
    send_req(sector_lookup(20'd3000, 1'b1));     // unused size code reads as 2352
    send_req(sector_lookup(20'hFFFFE, 1'b0));    // offset spills into bit 32
    send_req(sector_lookup(20'hFFFFF, 1'b1));    // at the lead-out
  endtask

  task automatic test_unsorted_table();
    send_req(table_write(127, 20'hFFFFF, 32'hFFFF_FFFF, SZ_2352_ALT, 1'b1, 8'hFF));
    send_req(table_write(2, 20'd100, 32'd77, SZ_2352, 1'b0, 8'd9));
    send_req(sector_lookup(20'd500, 1'b0));      // slots 0 and 2 both match
    send_req(sector_lookup(20'd120, 1'b1));
    send_req(sector_lookup(20'd2500, 1'b0));
  endtask

  task automatic test_count_extremes();
    int counts [4];
    counts = '{2, 128, 129, 255};
    set_track_count(0);
    write_track_table(MAX_TRACKS, 1'b1);
    foreach (counts[i]) begin
      set_track_count(counts[i]);
      send_req(sector_lookup(20'hFFFFF, 1'b0));
      repeat (6) send_req(sector_lookup(pick_sector(MAX_TRACKS), 1'($urandom)));
    end
  endtask

  // Hold responses long enough that the internal queue fills and input stalls.
  task automatic test_backpressure();
    set_track_count(6);
    write_track_table(6, 1'b1);
    rsp_hold_cycles = 300;
    repeat (12) send_req(sector_lookup(pick_sector(6), 1'($urandom)));
  endtask

  task automatic test_random_traffic();
    int cnt;
    int eff;
    int r;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 29);
      case (r)
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = 2;
        3:       cnt = 128;
        4:       cnt = 255;
        5:       cnt = $urandom_range(129, 254);
        6:       cnt = $urandom_range(20, 127);
        default: cnt = $urandom_range(3, 12);
      endcase
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      set_track_count(cnt);
      eff = (cnt > MAX_TRACKS) ? MAX_TRACKS : cnt;
      write_track_table(eff, $urandom_range(0, 7) != 0);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 19) == 0)
          send_req(table_write($urandom_range(0, 127), 20'($urandom), $urandom,
                               2'($urandom), 1'($urandom), 8'($urandom)));
        else
          send_req(sector_lookup(pick_sector(eff), 1'($urandom)));
      end
    end
  endtask

  task automatic test_steady_stream();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    set_track_count(10);
    write_track_table(10, 1'b1);
    repeat (60) send_req(sector_lookup(pick_sector(10), 1'($urandom)));
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_ch.valid           = 1'b0;
    cfg_ch.data            = '0;
    req_ch.valid           = 1'b0;
    req_ch.kind            = KIND_WRITE;
    req_ch.entry_index     = '0;
    req_ch.entry_start     = '0;
    req_ch.entry_skip      = '0;
    req_ch.entry_size_code = '0;
    req_ch.entry_mode2     = 1'b0;
    req_ch.entry_file_id   = '0;
    req_ch.sector          = '0;
    req_ch.raw_request     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    test_track_types();
    test_unsorted_table();
    test_count_extremes();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();

    drain_results(END_PAD);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
